FILE: hdl/brute_force_knn_store_macros.svh
// Assertion macros used by the checker file of the vector store.
`ifndef BRUTE_FORCE_KNN_STORE_MACROS_SVH
`define BRUTE_FORCE_KNN_STORE_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define BFKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define BFKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/bfks_pkg.sv
// Shared types, codes and constants of the vector store.
`timescale 1ns / 1ps
package bfks_pkg;

  localparam int MAX_DIM_DEF      = 128;
  localparam int STORE_DEPTH_DEF  = 256;
  localparam int MAX_K_DEF        = 16;
  localparam int ELEMENT_BITS_DEF = 16;

  localparam int ID_W    = 32;
  localparam int SCORE_W = 42;
  localparam int RANK_W  = 4;
  localparam int STAT_W  = 2;
  localparam int CMD_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT      = 3'd0,
    CMD_REMOVE      = 3'd1,
    CMD_CLEAR       = 3'd2,
    CMD_QUERY       = 3'd3,
    CMD_ALLOW       = 3'd4,
    CMD_CLEAR_MARKS = 3'd5
  } cmd_e;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM    = 2'd2;

  typedef struct packed {
    logic                      valid;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
    logic metric_ip;
  } chain_ctrl_t;

endpackage

FILE: hdl/bfks_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bfks_ram #(
  parameter int Width = 16,
  parameter int Depth = 128,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hdl/bfks_cell.sv
// One cell of the sorted result chain: holds a ranked slot and trades with its neighbours.
`timescale 1ns / 1ps
module bfks_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bfks_pkg::chain_ctrl_t ctrl_i,
  input  bfks_pkg::slot_t       cand_i,
  input  bfks_pkg::slot_t       prev_i,
  input  logic                  prev_take_i,
  input  bfks_pkg::slot_t       next_i,
  output logic                  take_o,
  output bfks_pkg::slot_t       slot_o
);
  import bfks_pkg::*;

  slot_t slot_q, slot_d;
  logic  better;

  // A candidate only displaces a slot that it strictly beats, so ties keep the earlier entry.
  always_comb begin
    better = ctrl_i.metric_ip ? ($signed(cand_i.score) > $signed(slot_q.score))
                              : ($signed(cand_i.score) < $signed(slot_q.score));
    take_o = !slot_q.valid || better;
    slot_d = slot_q;
    priority if (ctrl_i.clear) begin
      slot_d = '0;
    end else if (ctrl_i.insert) begin
      if (prev_take_i) begin
        slot_d = prev_i;
      end else if (take_o) begin
        slot_d       = cand_i;
        slot_d.valid = 1'b1;
      end
    end else if (ctrl_i.shift) begin
      slot_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

FILE: hdl/brute_force_knn_store.sv
// Top level of the vector store with exhaustive top-k search.
`timescale 1ns / 1ps
// Input words are taken only while the block is idle. The last element of an insert copies the
// pending vector into the store, or reports full if the store already holds StoreDepth entries.
// A remove searches the ids at one per cycle and then moves every later row down one element
// per cycle, then every later id down one place. An allow sweeps all ids once and marks the
// matches. The last element of a query scores every entry, only marked ones when the filter is
// used, with one multiply and accumulate per cycle on the vector RAM read port; the ranked list
// sits in a chain of MaxK cells, and its k result words then leave at one per cycle while the
// output is ready. Other commands end with a single status word. No clearing pass is needed
// after reset.
module brute_force_knn_store #(
  parameter int MaxDim      = bfks_pkg::MAX_DIM_DEF,
  parameter int StoreDepth  = bfks_pkg::STORE_DEPTH_DEF,
  parameter int MaxK        = bfks_pkg::MAX_K_DEF,
  parameter int ElementBits = bfks_pkg::ELEMENT_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bfks_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bfks_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [bfks_pkg::CMD_W-1:0]            cmd_i,
  input  logic signed [ElementBits-1:0]         element_i,
  input  logic [bfks_pkg::ID_W-1:0]             entry_id_i,
  input  logic                                  last_element_i,
  input  logic                                  use_filter_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [bfks_pkg::STAT_W-1:0]           status_o,
  output logic [bfks_pkg::RANK_W-1:0]           rank_o,
  output logic [bfks_pkg::ID_W-1:0]             result_id_o,
  output logic signed [bfks_pkg::SCORE_W-1:0]   score_o,
  output logic                                  slot_valid_o,
  output logic                                  last_result_o
);
  import bfks_pkg::*;

  localparam int SawRaw = $clog2(StoreDepth * MaxDim);
  localparam int Saw    = (SawRaw > 0) ? SawRaw : 1;
  localparam int Aw     = Saw + 1;
  localparam int Paw    = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int Cw     = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int Cntw   = $clog2(StoreDepth + 1);
  localparam int Dcw    = $clog2(MaxDim + 1);
  localparam int Kcw    = $clog2(MaxK + 1);
  localparam int Eb     = ElementBits;
  localparam int Mulw   = ((Eb > 22) ? Eb : 22) + 1;
  localparam int Sumw   = ((2 * Mulw > SCORE_W + 1) ? 2 * Mulw : SCORE_W + 1) + 1;
  localparam logic [Mulw-1:0] MagLim = Mulw'(1) << 21;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_COPY    = 9'b000000010,
    ST_FIND    = 9'b000000100,
    ST_SHIFT   = 9'b000001000,
    ST_IDSHIFT = 9'b000010000,
    ST_SCORE   = 9'b000100000,
    ST_EMIT    = 9'b001000000,
    ST_REPORT  = 9'b010000000,
    ST_WAIT    = 9'b100000000
  } state_e;

  state_e st_q, st_d;

  logic                 metric_q;
  logic [4:0]           rc_q;
  logic [7:0]           dim_q;
  logic [Dcw-1:0]       dim_eff;
  logic [Kcw-1:0]       k_eff;

  logic [Cntw-1:0]      cnt_q, cnt_d;
  logic [Dcw-1:0]       pos_q, pos_d;
  logic [MaxDim-1:0]    pflag_q, pflag_d, qflag_q, qflag_d;
  logic [StoreDepth-1:0] marks_q, marks_d, marks_dn;
  logic [Aw-1:0]        a_q, a_d, lim_q, lim_d, wbase_q, wbase_d;
  logic [Cntw-1:0]      e_q, e_d;
  logic [Dcw-1:0]       j_q, j_d;
  logic [ID_W-1:0]      tgt_q, tgt_d;
  logic                 rem_q, rem_d, filt_q, filt_d;
  logic [STAT_W-1:0]    status_q, status_d;
  logic [Kcw-1:0]       rank_q, rank_d;

  logic                 issue;
  logic                 d1_v_q, d1_first_q, d1_last_q, d1_f_q;
  logic                 d1_first_d, d1_last_d, d1_f_d;
  logic [Aw-1:0]        d1_a_q;
  logic [ID_W-1:0]      id_hold_q, id_cur;
  logic                 d2_v_q, d2_first_q, d2_last_q;
  logic signed [Sumw-1:0] d2_term_q, term;
  logic [ID_W-1:0]      d2_id_q;
  logic signed [SCORE_W-1:0] acc_q, sat;
  logic signed [Sumw-1:0] sum_base, sum;
  logic                 cand_v_q;
  slot_t                cand_q;

  logic signed [Mulw-1:0]   q_x, s_x, diff, mag, op_a, op_b;
  logic signed [2*Mulw-1:0] prod;
  logic                     over;

  logic                 in_fire, out_free, id_match;
  logic                 out_v_q, out_v_d;
  logic [STAT_W-1:0]    out_status_q, out_status_d;
  logic [RANK_W-1:0]    out_rank_q, out_rank_d;
  logic [ID_W-1:0]      out_id_q, out_id_d;
  logic signed [SCORE_W-1:0] out_score_q, out_score_d;
  logic                 out_sv_q, out_sv_d, out_last_q, out_last_d;

  logic                 s_we, p_we, q_we, i_we;
  logic [Saw-1:0]       s_waddr, s_raddr;
  logic [Eb-1:0]        s_wdata;
  logic signed [Eb-1:0] s_rdata, p_rdata, q_rdata;
  logic [Paw-1:0]       p_raddr, q_raddr, pq_waddr;
  logic [Cw-1:0]        i_waddr, i_raddr;
  logic [ID_W-1:0]      i_wdata, i_rdata;

  chain_ctrl_t          ctrl;
  slot_t                cell_slot [MaxK];
  logic                 cell_take [MaxK];

  // Register range handling.
  always_comb begin
    if (dim_q == '0) begin
      dim_eff = Dcw'(1);
    end else if (int'(dim_q) > MaxDim) begin
      dim_eff = Dcw'(MaxDim);
    end else begin
      dim_eff = Dcw'(dim_q);
    end
    if (rc_q == '0) begin
      k_eff = Kcw'(1);
    end else if (int'(rc_q) > MaxK) begin
      k_eff = Kcw'(MaxK);
    end else begin
      k_eff = Kcw'(rc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= 1'b0;
      rc_q     <= 5'd1;
      dim_q    <= 8'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_METRIC: metric_q <= cfg_data_i[0];
        CFG_COUNT:  rc_q     <= cfg_data_i[4:0];
        CFG_DIM:    dim_q    <= cfg_data_i;
        default:    metric_q <= metric_q;
      endcase
    end
  end

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_v_q || out_ready_i;
  assign id_match   = d1_v_q && (i_rdata == tgt_q);
  assign marks_dn   = marks_q >> 1;

  // Sequencer.
  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    pflag_d  = pflag_q;
    qflag_d  = qflag_q;
    marks_d  = marks_q;
    a_d      = a_q;
    lim_d    = lim_q;
    wbase_d  = wbase_q;
    e_d      = e_q;
    j_d      = j_q;
    tgt_d    = tgt_q;
    rem_d    = rem_q;
    filt_d   = filt_q;
    status_d = status_q;
    rank_d   = rank_q;
    issue      = 1'b0;
    d1_first_d = 1'b0;
    d1_last_d  = 1'b0;
    d1_f_d     = 1'b0;
    p_we     = 1'b0;
    q_we     = 1'b0;
    pq_waddr = pos_q[Paw-1:0];
    i_we     = 1'b0;
    i_waddr  = cnt_q[Cw-1:0];
    i_wdata  = entry_id_i;
    i_raddr  = a_q[Cw-1:0];
    s_we     = 1'b0;
    s_waddr  = Saw'(wbase_q + d1_a_q);
    s_wdata  = d1_f_q ? p_rdata : '0;
    s_raddr  = a_q[Saw-1:0];
    p_raddr  = a_q[Paw-1:0];
    q_raddr  = j_q[Paw-1:0];
    ctrl     = '0;
    ctrl.metric_ip = metric_q;
    ctrl.insert    = cand_v_q;
    out_v_d      = out_v_q && !out_ready_i;
    out_status_d = out_status_q;
    out_rank_d   = out_rank_q;
    out_id_d     = out_id_q;
    out_score_d  = out_score_q;
    out_sv_d     = out_sv_q;
    out_last_d   = out_last_q;

    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd_i)
            CMD_INSERT, CMD_QUERY: begin
              if (pos_q < dim_eff) begin
                if (cmd_i == CMD_INSERT) begin
                  p_we = 1'b1;
                  pflag_d[pos_q[Paw-1:0]] = 1'b1;
                end else begin
                  q_we = 1'b1;
                  qflag_d[pos_q[Paw-1:0]] = 1'b1;
                end
                pos_d = pos_q + Dcw'(1);
              end
              if (last_element_i) begin
                pos_d = '0;
                if (cmd_i == CMD_QUERY) begin
                  ctrl.clear = 1'b1;
                  filt_d = use_filter_i;
                  a_d    = '0;
                  e_d    = '0;
                  j_d    = '0;
                  st_d   = ST_SCORE;
                end else if (int'(cnt_q) >= StoreDepth) begin
                  pflag_d  = '0;
                  qflag_d  = '0;
                  status_d = STATUS_FULL;
                  st_d     = ST_REPORT;
                end else begin
                  i_we    = 1'b1;
                  wbase_d = Aw'(cnt_q * Aw'(MaxDim));
                  a_d     = '0;
                  st_d    = ST_COPY;
                end
              end
            end
            CMD_REMOVE, CMD_ALLOW: begin
              tgt_d = entry_id_i;
              rem_d = (cmd_i == CMD_REMOVE);
              a_d   = '0;
              st_d  = ST_FIND;
            end
            CMD_CLEAR: begin
              cnt_d    = '0;
              marks_d  = '0;
              status_d = STATUS_OK;
              st_d     = ST_REPORT;
            end
            CMD_CLEAR_MARKS: begin
              marks_d  = '0;
              status_d = STATUS_OK;
              st_d     = ST_REPORT;
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_COPY: begin
        s_we = d1_v_q;
        if (a_q < Aw'(MaxDim)) begin
          issue  = 1'b1;
          d1_f_d = pflag_q[a_q[Paw-1:0]];
          a_d    = a_q + Aw'(1);
        end else if (!d1_v_q) begin
          marks_d[cnt_q[Cw-1:0]] = 1'b0;
          cnt_d    = cnt_q + Cntw'(1);
          pflag_d  = '0;
          qflag_d  = '0;
          status_d = STATUS_OK;
          st_d     = ST_REPORT;
        end
      end
      ST_FIND: begin
        if (rem_q && id_match) begin
          e_d   = Cntw'(d1_a_q);
          a_d   = Aw'((d1_a_q + Aw'(1)) * Aw'(MaxDim));
          lim_d = Aw'(cnt_q * Aw'(MaxDim));
          st_d  = ST_SHIFT;
        end else begin
          if (id_match) begin
            marks_d[d1_a_q[Cw-1:0]] = 1'b1;
          end
          if (a_q < Aw'(cnt_q)) begin
            issue = 1'b1;
            a_d   = a_q + Aw'(1);
          end else if (!d1_v_q) begin
            status_d = rem_q ? STATUS_NOT_FOUND : STATUS_OK;
            st_d     = ST_REPORT;
          end
        end
      end
      ST_SHIFT: begin
        s_we    = d1_v_q;
        s_waddr = Saw'(d1_a_q - Aw'(MaxDim));
        s_wdata = s_rdata;
        if (a_q < lim_q) begin
          issue = 1'b1;
          a_d   = a_q + Aw'(1);
        end else if (!d1_v_q) begin
          a_d  = Aw'(e_q) + Aw'(1);
          st_d = ST_IDSHIFT;
        end
      end
      ST_IDSHIFT: begin
        i_we    = d1_v_q;
        i_waddr = Cw'(d1_a_q - Aw'(1));
        i_wdata = i_rdata;
        if (a_q < Aw'(cnt_q)) begin
          issue = 1'b1;
          a_d   = a_q + Aw'(1);
        end else if (!d1_v_q) begin
          for (int i = 0; i < StoreDepth; i++) begin
            if (Cntw'(i) >= e_q) begin
              marks_d[i] = marks_dn[i];
            end
          end
          cnt_d    = cnt_q - Cntw'(1);
          status_d = STATUS_OK;
          st_d     = ST_REPORT;
        end
      end
      ST_SCORE: begin
        s_raddr = Saw'(a_q + Aw'(j_q));
        i_raddr = e_q[Cw-1:0];
        if (e_q < cnt_q) begin
          if (filt_q && !marks_q[e_q[Cw-1:0]]) begin
            e_d = e_q + Cntw'(1);
            a_d = a_q + Aw'(MaxDim);
          end else begin
            issue      = 1'b1;
            d1_first_d = (j_q == '0);
            d1_last_d  = (j_q == dim_eff - Dcw'(1));
            d1_f_d     = qflag_q[j_q[Paw-1:0]];
            if (d1_last_d) begin
              j_d = '0;
              e_d = e_q + Cntw'(1);
              a_d = a_q + Aw'(MaxDim);
            end else begin
              j_d = j_q + Dcw'(1);
            end
          end
        end else if (!d1_v_q && !d2_v_q && !cand_v_q) begin
          pflag_d = '0;
          qflag_d = '0;
          rank_d  = '0;
          st_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctrl.shift   = 1'b1;
          out_v_d      = 1'b1;
          out_status_d = STATUS_OK;
          out_rank_d   = RANK_W'(rank_q);
          out_sv_d     = cell_slot[0].valid;
          out_id_d     = cell_slot[0].valid ? cell_slot[0].id : '0;
          out_score_d  = cell_slot[0].valid ? cell_slot[0].score : '0;
          out_last_d   = (rank_q == k_eff - Kcw'(1));
          rank_d       = rank_q + Kcw'(1);
          if (out_last_d) begin
            st_d = ST_IDLE;
          end
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_v_d      = 1'b1;
          out_status_d = status_q;
          out_rank_d   = '0;
          out_sv_d     = 1'b0;
          out_id_d     = '0;
          out_score_d  = '0;
          out_last_d   = 1'b1;
          st_d         = ST_WAIT;
        end
      end
      ST_WAIT: begin
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Score pipeline: term, then saturating accumulate.
  always_comb begin
    q_x  = d1_f_q ? Mulw'(q_rdata) : '0;
    s_x  = Mulw'(s_rdata);
    diff = q_x - s_x;
    mag  = diff[Mulw-1] ? -diff : diff;
    over = !metric_q && ($unsigned(mag) > MagLim);
    op_a = metric_q ? q_x : mag;
    op_b = metric_q ? s_x : mag;
    prod = op_a * op_b;
    term = over ? Sumw'(SCORE_MAX) : Sumw'(prod);
    id_cur = d1_first_q ? i_rdata : id_hold_q;

    sum_base = d2_first_q ? '0 : Sumw'(acc_q);
    sum      = sum_base + d2_term_q;
    if (sum > Sumw'(SCORE_MAX)) begin
      sat = SCORE_MAX;
    end else if (sum < Sumw'(SCORE_MIN)) begin
      sat = SCORE_MIN;
    end else begin
      sat = sum[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      cnt_q    <= '0;
      pos_q    <= '0;
      pflag_q  <= '0;
      qflag_q  <= '0;
      marks_q  <= '0;
      a_q      <= '0;
      e_q      <= '0;
      j_q      <= '0;
      rank_q   <= '0;
      d1_v_q   <= 1'b0;
      d2_v_q   <= 1'b0;
      cand_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      pflag_q  <= pflag_d;
      qflag_q  <= qflag_d;
      marks_q  <= marks_d;
      a_q      <= a_d;
      e_q      <= e_d;
      j_q      <= j_d;
      rank_q   <= rank_d;
      d1_v_q   <= issue;
      d2_v_q   <= d1_v_q && (st_q == ST_SCORE);
      cand_v_q <= d2_v_q && d2_last_q;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q        <= lim_d;
    wbase_q      <= wbase_d;
    tgt_q        <= tgt_d;
    rem_q        <= rem_d;
    filt_q       <= filt_d;
    status_q     <= status_d;
    d1_a_q       <= a_q;
    d1_first_q   <= d1_first_d;
    d1_last_q    <= d1_last_d;
    d1_f_q       <= d1_f_d;
    id_hold_q    <= id_cur;
    d2_first_q   <= d1_first_q;
    d2_last_q    <= d1_last_q;
    d2_term_q    <= term;
    d2_id_q      <= id_cur;
    if (d2_v_q) begin
      acc_q <= sat;
    end
    cand_q.valid <= 1'b1;
    cand_q.id    <= d2_id_q;
    cand_q.score <= sat;
    out_status_q <= out_status_d;
    out_rank_q   <= out_rank_d;
    out_id_q     <= out_id_d;
    out_score_q  <= out_score_d;
    out_sv_q     <= out_sv_d;
    out_last_q   <= out_last_d;
  end

  bfks_ram #(.Width(Eb), .Depth(StoreDepth * MaxDim)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  bfks_ram #(.Width(Eb), .Depth(MaxDim)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (pq_waddr),
    .wdata_i (element_i),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  bfks_ram #(.Width(Eb), .Depth(MaxDim)) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (pq_waddr),
    .wdata_i (element_i),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  bfks_ram #(.Width(ID_W), .Depth(StoreDepth)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (i_waddr),
    .wdata_i (i_wdata),
    .raddr_i (i_raddr),
    .rdata_o (i_rdata)
  );

  for (genvar g = 0; g < MaxK; g++) begin : g_cell
    slot_t prev_s, next_s;
    logic  prev_t;
    if (g == 0) begin : g_head
      assign prev_s = '0;
      assign prev_t = 1'b0;
    end else begin : g_body
      assign prev_s = cell_slot[g-1];
      assign prev_t = cell_take[g-1];
    end
    if (g == MaxK - 1) begin : g_tail
      assign next_s = '0;
    end else begin : g_link
      assign next_s = cell_slot[g+1];
    end
    bfks_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .cand_i      (cand_q),
      .prev_i      (prev_s),
      .prev_take_i (prev_t),
      .next_i      (next_s),
      .take_o      (cell_take[g]),
      .slot_o      (cell_slot[g])
    );
  end

  assign out_valid_o   = out_v_q;
  assign status_o      = out_status_q;
  assign rank_o        = out_rank_q;
  assign result_id_o   = out_id_q;
  assign score_o       = out_score_q;
  assign slot_valid_o  = out_sv_q;
  assign last_result_o = out_last_q;

endmodule

FILE: hdl/bfks_checker.sv
// Port-level checker for the vector store, bound to the top level.
`timescale 1ns / 1ps
`include "brute_force_knn_store_macros.svh"
module bfks_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [bfks_pkg::STAT_W-1:0]         status_o,
  input logic [bfks_pkg::ID_W-1:0]           result_id_o,
  input logic signed [bfks_pkg::SCORE_W-1:0] score_o,
  input logic                                slot_valid_o,
  input logic                                last_result_o
);
  import bfks_pkg::*;

  logic err_word, pad_word;

  assign err_word = out_valid_o && (status_o != STATUS_OK);
  assign pad_word = out_valid_o && !slot_valid_o;

  `BFKS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped")

  `BFKS_ASSERT(a_status_word, err_word |-> !slot_valid_o && last_result_o, "status on ranked word")

  `BFKS_ASSERT(a_pad_zero, pad_word |-> result_id_o == '0 && score_o == '0, "padding carries data")

  `BFKS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result word during reset")

endmodule

bind brute_force_knn_store bfks_checker u_bfks_checker (.*);
